// ===== hw/rtl/ovab_pkg.sv =====
// Package for the oriented vector angle block.
// Holds the shared widths, angle constants, the CORDIC arctangent table
// and the type that carries one item from the front part to the back part.
package ovab_pkg;

    localparam int DEF_COORD_WIDTH       = 32;
    localparam int DEF_ANGLE_FRAC_BITS   = 28;
    localparam int DEF_CORDIC_ITERATIONS = 28;

    localparam int FIELD_W  = 32;
    localparam int PROD_W   = 64;
    localparam int CROSS_W  = PROD_W + 1;
    localparam int ZACC_W   = 36;
    localparam int ANGLE_W  = 31;
    localparam int TOL_W    = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic signed [ZACC_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [ZACC_W-1:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [ZACC_W-1:0] TWO_PI_Q30  = 36'sd6746518852;

    localparam logic [0:0] REG_ZERO_TOL = 1'b0;

    typedef struct packed {
        logic                     degenerate;
        logic                     negative;
        logic signed [PROD_W-1:0] x;
        logic signed [PROD_W-1:0] y;
    } t_mid;

    function automatic logic signed [ZACC_W-1:0] atan_q30(input int idx);
        logic signed [ZACC_W-1:0] v;
        v = '0;
        unique case (idx)
            0:  v = 36'sd843314857;
            1:  v = 36'sd497837829;
            2:  v = 36'sd263043837;
            3:  v = 36'sd133525159;
            4:  v = 36'sd67021687;
            5:  v = 36'sd33543516;
            6:  v = 36'sd16775851;
            7:  v = 36'sd8388437;
            8:  v = 36'sd4194283;
            9:  v = 36'sd2097149;
            default: begin
                if (idx >= 10 && idx <= 30) begin
                    v = ZACC_W'(36'sd1 <<< (30 - idx));
                end else begin
                    v = '0;
                end
            end
        endcase
        return v;
    endfunction

    // Signed division by four, truncated toward zero.
    function automatic logic signed [PROD_W-1:0] div4_trunc(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] t;
        t = v + (v[PROD_W-1] ? PROD_W'(3) : PROD_W'(0));
        return t >>> 2;
    endfunction

endpackage

// ===== hw/rtl/ovab_front.sv =====
// Front part: takes in vector pairs, forms the products, and classifies
// each item (degenerate, orientation) with its CORDIC operands.
// Depends on ovab_pkg.
module ovab_front
    import ovab_pkg::*;
#(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [FIELD_W-1:0] i_first_x,
    input  logic [FIELD_W-1:0] i_first_y,
    input  logic [FIELD_W-1:0] i_second_x,
    input  logic [FIELD_W-1:0] i_second_y,
    input  logic [TOL_W-1:0]   i_tol,
    input  logic               i_q_full,
    output logic               o_full,
    output logic               o_mid_valid,
    output t_mid               o_mid
);

    logic signed [FIELD_W-1:0] ax, ay, bx, by;
    logic                      en;
    logic                      r_s1_valid, r_s2_valid;
    logic signed [PROD_W-1:0]  r_aa_x, r_aa_y, r_bb_x, r_bb_y;
    logic signed [PROD_W-1:0]  r_ab_x, r_ab_y, r_axby, r_aybx;
    logic signed [PROD_W-1:0]  n_aa_x, n_aa_y, n_bb_x, n_bb_y;
    logic signed [PROD_W-1:0]  n_ab_x, n_ab_y, n_axby, n_aybx;
    logic [PROD_W-1:0]         len_a, len_b, tol_sq;
    logic signed [CROSS_W-1:0] cross_prod, tol_neg;
    logic [CROSS_W-1:0]        cross_mag;
    t_mid                      n_mid, r_mid;

    assign ax = FIELD_W'(signed'(i_first_x[COORD_WIDTH-1:0]));
    assign ay = FIELD_W'(signed'(i_first_y[COORD_WIDTH-1:0]));
    assign bx = FIELD_W'(signed'(i_second_x[COORD_WIDTH-1:0]));
    assign by = FIELD_W'(signed'(i_second_y[COORD_WIDTH-1:0]));

    assign n_aa_x = ax * ax;
    assign n_aa_y = ay * ay;
    assign n_bb_x = bx * bx;
    assign n_bb_y = by * by;
    assign n_ab_x = ax * bx;
    assign n_ab_y = ay * by;
    assign n_axby = ax * by;
    assign n_aybx = ay * bx;

    // The front advances unless its last stage holds an item the queue cannot take.
    assign en          = !r_s2_valid || !i_q_full;
    assign o_full      = !en;
    assign o_mid_valid = r_s2_valid && !i_q_full;
    assign o_mid       = r_mid;

    always_comb begin
        len_a      = unsigned'(r_aa_x) + unsigned'(r_aa_y);
        len_b      = unsigned'(r_bb_x) + unsigned'(r_bb_y);
        tol_sq     = PROD_W'(i_tol) * PROD_W'(i_tol);
        cross_prod = CROSS_W'(r_axby) - CROSS_W'(r_aybx);
        tol_neg    = -signed'({{(CROSS_W-TOL_W-16){1'b0}}, i_tol, 16'h0000});
        cross_mag  = cross_prod[CROSS_W-1] ? unsigned'(-cross_prod) : unsigned'(cross_prod);
        n_mid.degenerate = (len_a <= tol_sq) || (len_b <= tol_sq);
        n_mid.negative   = cross_prod < tol_neg;
        n_mid.x          = div4_trunc(r_ab_x) + div4_trunc(r_ab_y);
        n_mid.y          = signed'(PROD_W'(cross_mag >> 2));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= i_push;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_aa_x <= n_aa_x;
            r_aa_y <= n_aa_y;
            r_bb_x <= n_bb_x;
            r_bb_y <= n_bb_y;
            r_ab_x <= n_ab_x;
            r_ab_y <= n_ab_y;
            r_axby <= n_axby;
            r_aybx <= n_aybx;
            r_mid  <= n_mid;
        end
    end

endmodule

// ===== hw/rtl/ovab_queue.sv =====
// Short register queue between the front and back parts.
// Depends on ovab_pkg.
module ovab_queue
    import ovab_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_mid i_data,
    input  logic i_pop,
    output logic o_full,
    output logic o_nonempty,
    output t_mid o_data
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_mid            r_mem [QUEUE_DEPTH];
    logic [PW-1:0]   r_wr, r_rd;
    logic [PW:0]     r_count;

    assign o_full     = (r_count == (PW+1)'(QUEUE_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_data     = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== hw/rtl/ovab_back.sv =====
// Back part: unrolled CORDIC vectoring pipeline, then clamp, orientation
// fix-up and rounding into the output register. Depends on ovab_pkg.
module ovab_back
    import ovab_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS   = DEF_ANGLE_FRAC_BITS,
    parameter int CORDIC_ITERATIONS = DEF_CORDIC_ITERATIONS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_nonempty,
    input  t_mid               i_q_data,
    input  logic               i_pop,
    output logic               o_q_pop,
    output logic               o_empty,
    output logic [ANGLE_W-1:0] o_angle_rad,
    output logic               o_degenerate
);

    localparam int N  = CORDIC_ITERATIONS;
    localparam int SH = 30 - ANGLE_FRAC_BITS;

    logic                     en;
    logic                     r_valid [N+1];
    logic                     r_deg   [N+1];
    logic                     r_neg   [N+1];
    logic signed [PROD_W-1:0] r_x     [N+1];
    logic signed [PROD_W-1:0] r_y     [N+1];
    logic signed [ZACC_W-1:0] r_z     [N+1];
    logic                     r_out_valid;
    logic [ANGLE_W-1:0]       r_angle;
    logic                     r_out_deg;
    logic signed [ZACC_W-1:0] z_clamp, z_final;
    logic [ANGLE_W-1:0]       n_angle;

    // The whole back pipeline moves when the output register is free or being read.
    assign en           = !r_out_valid || i_pop;
    assign o_q_pop      = en && i_q_nonempty;
    assign o_empty      = !r_out_valid;
    assign o_angle_rad  = r_angle;
    assign o_degenerate = r_out_deg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (en) begin
            r_valid[0] <= i_q_nonempty;
        end
    end

    // Operands in the left half plane are first turned by a quarter turn.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_deg[0] <= i_q_data.degenerate;
            r_neg[0] <= i_q_data.negative;
            if (i_q_data.x[PROD_W-1]) begin
                r_x[0] <= i_q_data.y;
                r_y[0] <= -i_q_data.x;
                r_z[0] <= HALF_PI_Q30;
            end else begin
                r_x[0] <= i_q_data.x;
                r_y[0] <= i_q_data.y;
                r_z[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[i+1] <= 1'b0;
            end else if (en) begin
                r_valid[i+1] <= r_valid[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_deg[i+1] <= r_deg[i];
                r_neg[i+1] <= r_neg[i];
                if (r_y[i] > 0) begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + atan_q30(i);
                end else begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - atan_q30(i);
                end
            end
        end
    end

    always_comb begin
        if (r_z[N] < 0) begin
            z_clamp = '0;
        end else if (r_z[N] > PI_Q30) begin
            z_clamp = PI_Q30;
        end else begin
            z_clamp = r_z[N];
        end
        z_final = r_neg[N] ? (TWO_PI_Q30 - z_clamp) : z_clamp;
        n_angle = ANGLE_W'((z_final + (ZACC_W'(1) <<< (SH - 1))) >>> SH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_valid[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_deg <= r_deg[N];
            r_angle   <= r_deg[N] ? '0 : n_angle;
        end
    end

endmodule

// ===== hw/rtl/oriented_angle_between_vectors.sv =====
// Top level of the oriented vector angle block.
// Instantiates ovab_front, ovab_queue and ovab_back; depends on ovab_pkg.
//
// Usage:
//   Input channel: drive the four Q16.16 components and raise push; the pair
//   is transferred at a clock edge where push is high and full is low.
//   Result channel: while empty is low the oldest result (angle in unsigned
//   Q3.28 radians, counter-clockwise from first to second vector, plus the
//   degenerate flag) is on the outputs; it is transferred when pop is high.
//   Configuration: APB-style port, one register at address 0, zero_tolerance
//   (16 bits, reset value 1). Write it only while no items are in flight.
//   Path from input transfer to empty going low: the front stages, the
//   queue, pre-rotation, the CORDIC stages and the output register.
//   Throughput: one pair per cycle while full is low, set by the unrolled
//   CORDIC pipeline with one stage per iteration.
//   Stalls: when pop is low while a result waits, the back pipeline holds; the
//   front accepts until the two-entry queue and last stage fill, then raises full.
//   Reset: synchronous, active low; clears all valid state, empties the queue
//   and sets zero_tolerance to 1.
module oriented_angle_between_vectors
    import ovab_pkg::*;
#(
    parameter int COORD_WIDTH       = DEF_COORD_WIDTH,
    parameter int ANGLE_FRAC_BITS   = DEF_ANGLE_FRAC_BITS,
    parameter int CORDIC_ITERATIONS = DEF_CORDIC_ITERATIONS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [FIELD_W-1:0] i_first_x,
    input  logic [FIELD_W-1:0] i_first_y,
    input  logic [FIELD_W-1:0] i_second_x,
    input  logic [FIELD_W-1:0] i_second_y,
    output logic               empty,
    input  logic               pop,
    output logic [ANGLE_W-1:0] o_angle_rad,
    output logic               o_degenerate,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [0:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic             r_zero_tol;
    logic [TOL_W-1:0] r_tol;
    logic             q_full, q_nonempty, q_pop, mid_valid;
    t_mid             mid, q_data;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_ZERO_TOL) ? {16'h0000, r_tol} : 32'h0000_0000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol      <= TOL_W'(1);
            r_zero_tol <= 1'b1;
        end else begin
            if (psel && penable && pwrite && pready && paddr == REG_ZERO_TOL) begin
                r_tol <= pwdata[TOL_W-1:0];
            end
            r_zero_tol <= (r_tol == '0);
        end
    end

    ovab_front #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_first_x  (i_first_x),
        .i_first_y  (i_first_y),
        .i_second_x (i_second_x),
        .i_second_y (i_second_y),
        .i_tol      (r_tol),
        .i_q_full   (q_full),
        .o_full     (full),
        .o_mid_valid(mid_valid),
        .o_mid      (mid)
    );

    ovab_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (mid_valid),
        .i_data    (mid),
        .i_pop     (q_pop),
        .o_full    (q_full),
        .o_nonempty(q_nonempty),
        .o_data    (q_data)
    );

    ovab_back #(
        .ANGLE_FRAC_BITS  (ANGLE_FRAC_BITS),
        .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_nonempty(q_nonempty),
        .i_q_data    (q_data),
        .i_pop       (pop),
        .o_q_pop     (q_pop),
        .o_empty     (empty),
        .o_angle_rad (o_angle_rad),
        .o_degenerate(o_degenerate)
    );

    // A degenerate result always carries a zero angle.
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_degenerate) |-> (o_angle_rad == '0))
        else $error("degenerate result with nonzero angle");

    // The front never hands an item to a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mid_valid |-> !q_full)
        else $error("queue overflow");

    // The back only takes from the queue when it holds an item.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_nonempty)
        else $error("queue underflow");

    // The tolerance mirror reflects the register value from the previous cycle.
    a_tol_mirror: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_zero_tol == ($past(r_tol) == '0)))
        else $error("tolerance status out of step");

endmodule
